@@ rtl/biba_pkg.sv @@
package biba_pkg;

    // Default sizes
    localparam int INODE_MAP_WORDS_DEF = 32;
    localparam int DATA_MAP_WORDS_DEF  = 128;
    localparam int BLOCKS_PER_FILE_DEF = 4;

    // Field and register widths
    localparam int INO_LIM_W  = 11;
    localparam int DAT_LIM_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [INO_LIM_W-1:0] INO_LIM_RST = 11'd1024;
    localparam logic [DAT_LIM_W-1:0] DAT_LIM_RST = 13'd4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INODE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_LIMIT  = 1'b1;

    // Request types
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Map select
    localparam logic SEL_INODE = 1'b0;
    localparam logic SEL_DATA  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_INODE = 2'd0;
    localparam logic [1:0] KIND_BLOCK = 2'd1;
    localparam logic [1:0] KIND_WORD  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // Status codes
    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_NOSPACE = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        map_select;
        logic [6:0]  word_index;
        logic [31:0] word_value;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [1:0]  result_kind;
        logic [31:0] result_value;
        logic        last;
    } t_res;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RD_OUT,
        ST_I_FIND,
        ST_D_FIND,
        ST_I_WR,
        ST_B_RD,
        ST_B_WR,
        ST_FAIL
    } t_state;

endpackage

@@ rtl/bitmap_inode_block_allocator_unit.sv @@
// Channel   | Ports                               | Handshake
// ----------+-------------------------------------+------------------------------------
// request   | start, busy, i_req                  | taken when start & !busy
// result    | o_strobe, o_res                     | one cycle per result, no back-pressure
// config    | i_cfg_we, i_cfg_index, i_cfg_data   | written when i_cfg_we is high
//
// After reset both maps are cleared one word per cycle with busy high. An allocation
// walks the inode map and then the data map one word per cycle through one shared
// find-first-zero unit, staying on a data word while it still holds a free block.
// Word reads and writes each give a single result.
// Each result appears on o_res for one cycle with o_strobe; the receiver cannot stall.
module bitmap_inode_block_allocator_unit #(
    parameter int INODE_MAP_WORDS = biba_pkg::INODE_MAP_WORDS_DEF,
    parameter int DATA_MAP_WORDS  = biba_pkg::DATA_MAP_WORDS_DEF,
    parameter int BLOCKS_PER_FILE = biba_pkg::BLOCKS_PER_FILE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  biba_pkg::t_req                 i_req,
    output logic                           o_strobe,
    output biba_pkg::t_res                 o_res,
    input  logic                           i_cfg_we,
    input  logic [biba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [biba_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int MAXW   = (INODE_MAP_WORDS > DATA_MAP_WORDS) ? INODE_MAP_WORDS
                                                               : DATA_MAP_WORDS;
    localparam int WX     = (MAXW > 1) ? $clog2(MAXW) : 1;
    localparam int IAW    = (INODE_MAP_WORDS > 1) ? $clog2(INODE_MAP_WORDS) : 1;
    localparam int DAW    = (DATA_MAP_WORDS > 1) ? $clog2(DATA_MAP_WORDS) : 1;
    localparam int BITS_W = $clog2(MAXW * 32 + 1);
    localparam int BW     = (BITS_W > biba_pkg::DAT_LIM_W) ? BITS_W : biba_pkg::DAT_LIM_W;
    localparam int CW     = (BLOCKS_PER_FILE > 1) ? $clog2(BLOCKS_PER_FILE) : 1;
    localparam int CNT_W  = $clog2(BLOCKS_PER_FILE + 1);

    localparam logic [BW-1:0]    INO_CAP   = BW'(INODE_MAP_WORDS * 32);
    localparam logic [BW-1:0]    DAT_CAP   = BW'(DATA_MAP_WORDS * 32);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(BLOCKS_PER_FILE - 1);
    localparam logic [WX-1:0]    CLR_LAST  = WX'(MAXW - 1);

    // State and working registers
    biba_pkg::t_state r_state, n_state;
    biba_pkg::t_req   r_req, n_req;
    logic [WX-1:0]    r_widx, n_widx;
    logic             r_fresh, n_fresh;
    logic [31:0]      r_work, n_work;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [BW-1:0]    r_blk [BLOCKS_PER_FILE];
    logic [BW-1:0]    n_blk [BLOCKS_PER_FILE];
    logic [BW-1:0]    r_ino, n_ino;
    logic [31:0]      r_iword, n_iword;
    logic [WX-1:0]    r_clr, n_clr;
    logic             r_out_valid, n_out_valid;
    biba_pkg::t_res   r_out, n_out;

    logic [biba_pkg::INO_LIM_W-1:0] r_inode_limit;
    logic [biba_pkg::DAT_LIM_W-1:0] r_data_limit;

    // Map memories
    logic [31:0]    r_ino_map [INODE_MAP_WORDS];
    logic [31:0]    r_dat_map [DATA_MAP_WORDS];
    logic [31:0]    r_ird, r_drd;
    logic [WX-1:0]  mem_ra;
    logic           ino_we, dat_we;
    logic [IAW-1:0] ino_wa;
    logic [DAW-1:0] dat_wa;
    logic [31:0]    ino_wd, dat_wd;

    // Shared find unit signals
    logic [BW-1:0]   ino_bound, dat_bound, scan_bound;
    logic [BW-1:0]   scan_start, next_start, scan_diff;
    logic [WX:0]     widx_nx;
    logic [31:0]     scan_raw, scan_mask, scan_cur;
    logic            scan_hit;
    logic [4:0]      scan_pos;
    logic [BW-1:0]   scan_idx;
    logic            more_words;
    logic [CW-1:0]   blk_sel;
    logic [WX-1:0]   blk_word;
    logic            ino_in_range, dat_in_range;

    assign busy     = (r_state != biba_pkg::ST_IDLE);
    assign o_strobe = r_out_valid;
    assign o_res    = r_out;

    // Effective bounds: smaller of the limit and the map size
    always_comb begin
        ino_bound = (BW'(r_inode_limit) < INO_CAP) ? BW'(r_inode_limit) : INO_CAP;
        dat_bound = (BW'(r_data_limit) < DAT_CAP) ? BW'(r_data_limit) : DAT_CAP;
    end

    // Find-first-zero over the current word, with bits at or past the bound forced set
    always_comb begin
        if (r_state == biba_pkg::ST_D_FIND) begin
            scan_raw   = r_fresh ? r_drd : r_work;
            scan_bound = dat_bound;
        end else begin
            scan_raw   = r_ird;
            scan_bound = ino_bound;
        end
        scan_start = BW'({r_widx, 5'b0});
        widx_nx    = {1'b0, r_widx} + 1'b1;
        next_start = BW'({widx_nx, 5'b0});
        scan_diff  = scan_bound - scan_start;
        if (scan_bound <= scan_start) begin
            scan_mask = '1;
        end else if (scan_diff >= BW'(32)) begin
            scan_mask = '0;
        end else begin
            scan_mask = ~((32'd1 << scan_diff[4:0]) - 32'd1);
        end
        scan_cur = scan_raw | scan_mask;
        scan_hit = ~&scan_cur;
        scan_pos = 5'd0;
        for (int j = 31; j >= 0; j--) begin
            if (!scan_cur[j]) begin
                scan_pos = 5'(j);
            end
        end
        scan_idx   = BW'({r_widx, scan_pos});
        more_words = (next_start < scan_bound);
    end

    assign blk_sel      = r_cnt[CW-1:0];
    assign blk_word     = WX'(r_blk[blk_sel] >> 5);
    assign ino_in_range = (32'(r_req.word_index) < 32'(INODE_MAP_WORDS));
    assign dat_in_range = (32'(r_req.word_index) < 32'(DATA_MAP_WORDS));

    // Sequencer: next state, memory controls and result
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_widx      = r_widx;
        n_fresh     = r_fresh;
        n_work      = r_work;
        n_cnt       = r_cnt;
        n_blk       = r_blk;
        n_ino       = r_ino;
        n_iword     = r_iword;
        n_clr       = r_clr;
        n_out_valid = 1'b0;
        n_out       = r_out;
        mem_ra      = '0;
        ino_we      = 1'b0;
        dat_we      = 1'b0;
        ino_wa      = '0;
        dat_wa      = '0;
        ino_wd      = '0;
        dat_wd      = '0;

        case (r_state)
            biba_pkg::ST_CLEAR: begin
                ino_we = (32'(r_clr) < 32'(INODE_MAP_WORDS));
                dat_we = (32'(r_clr) < 32'(DATA_MAP_WORDS));
                ino_wa = IAW'(r_clr);
                dat_wa = DAW'(r_clr);
                n_clr  = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = biba_pkg::ST_IDLE;
                end
            end

            biba_pkg::ST_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = biba_pkg::ST_EXEC;
                end
            end

            biba_pkg::ST_EXEC: begin
                case (r_req.req_type)
                    biba_pkg::REQ_ALLOC: begin
                        mem_ra  = '0;
                        n_widx  = '0;
                        n_state = biba_pkg::ST_I_FIND;
                    end
                    biba_pkg::REQ_WRITE: begin
                        if (r_req.map_select == biba_pkg::SEL_DATA) begin
                            dat_we = dat_in_range;
                        end else begin
                            ino_we = ino_in_range;
                        end
                        ino_wa      = IAW'(r_req.word_index);
                        dat_wa      = DAW'(r_req.word_index);
                        ino_wd      = r_req.word_value;
                        dat_wd      = r_req.word_value;
                        n_out_valid = 1'b1;
                        n_out       = '{biba_pkg::STAT_OK, biba_pkg::KIND_DONE, 32'd0, 1'b1};
                        n_state     = biba_pkg::ST_IDLE;
                    end
                    biba_pkg::REQ_READ: begin
                        mem_ra  = WX'(r_req.word_index);
                        n_state = biba_pkg::ST_RD_OUT;
                    end
                    default: begin
                        n_state = biba_pkg::ST_IDLE;
                    end
                endcase
            end

            biba_pkg::ST_RD_OUT: begin
                n_out_valid = 1'b1;
                n_out.status      = biba_pkg::STAT_OK;
                n_out.result_kind = biba_pkg::KIND_WORD;
                n_out.last        = 1'b1;
                if (r_req.map_select == biba_pkg::SEL_DATA) begin
                    n_out.result_value = dat_in_range ? r_drd : 32'd0;
                end else begin
                    n_out.result_value = ino_in_range ? r_ird : 32'd0;
                end
                n_state = biba_pkg::ST_IDLE;
            end

            // Inode scan: one map word per cycle
            biba_pkg::ST_I_FIND: begin
                if (scan_hit) begin
                    n_ino   = scan_idx;
                    n_iword = r_ird | (32'd1 << scan_pos);
                    mem_ra  = '0;
                    n_widx  = '0;
                    n_fresh = 1'b1;
                    n_cnt   = '0;
                    n_state = biba_pkg::ST_D_FIND;
                end else if (more_words) begin
                    mem_ra  = widx_nx[WX-1:0];
                    n_widx  = widx_nx[WX-1:0];
                end else begin
                    n_state = biba_pkg::ST_FAIL;
                end
            end

            // Data scan: take one free block per cycle, move on when the word is full
            biba_pkg::ST_D_FIND: begin
                if (scan_hit) begin
                    n_blk[blk_sel] = scan_idx;
                    n_work         = scan_cur | (32'd1 << scan_pos);
                    n_fresh        = 1'b0;
                    n_cnt          = r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        n_state = biba_pkg::ST_I_WR;
                    end
                end else if (more_words) begin
                    mem_ra  = widx_nx[WX-1:0];
                    n_widx  = widx_nx[WX-1:0];
                    n_fresh = 1'b1;
                end else begin
                    n_state = biba_pkg::ST_FAIL;
                end
            end

            // Commit inode bit and report it
            biba_pkg::ST_I_WR: begin
                ino_we      = 1'b1;
                ino_wa      = IAW'(r_ino >> 5);
                ino_wd      = r_iword;
                n_out_valid = 1'b1;
                n_out       = '{biba_pkg::STAT_OK, biba_pkg::KIND_INODE, 32'(r_ino), 1'b0};
                n_cnt       = '0;
                n_state     = biba_pkg::ST_B_RD;
            end

            // Read-modify-write of each block's map word
            biba_pkg::ST_B_RD: begin
                mem_ra  = blk_word;
                n_state = biba_pkg::ST_B_WR;
            end

            biba_pkg::ST_B_WR: begin
                dat_we      = 1'b1;
                dat_wa      = DAW'(blk_word);
                dat_wd      = r_drd | (32'd1 << r_blk[blk_sel][4:0]);
                n_out_valid = 1'b1;
                n_out       = '{biba_pkg::STAT_OK, biba_pkg::KIND_BLOCK,
                                32'(r_blk[blk_sel]), (r_cnt == CNT_LAST)};
                n_cnt       = r_cnt + 1'b1;
                n_state     = (r_cnt == CNT_LAST) ? biba_pkg::ST_IDLE : biba_pkg::ST_B_RD;
            end

            biba_pkg::ST_FAIL: begin
                n_out_valid = 1'b1;
                n_out       = '{biba_pkg::STAT_NOSPACE, biba_pkg::KIND_DONE, 32'd0, 1'b1};
                n_state     = biba_pkg::ST_IDLE;
            end

            default: begin
                n_state = biba_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= biba_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_widx  <= n_widx;
        r_fresh <= n_fresh;
        r_work  <= n_work;
        r_cnt   <= n_cnt;
        r_blk   <= n_blk;
        r_ino   <= n_ino;
        r_iword <= n_iword;
        r_out   <= n_out;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inode_limit <= biba_pkg::INO_LIM_RST;
            r_data_limit  <= biba_pkg::DAT_LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                biba_pkg::CFG_INODE_LIMIT: begin
                    r_inode_limit <= i_cfg_data[biba_pkg::INO_LIM_W-1:0];
                end
                biba_pkg::CFG_DATA_LIMIT: begin
                    r_data_limit <= i_cfg_data[biba_pkg::DAT_LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Inode map memory
    always_ff @(posedge i_clk) begin
        if (ino_we) begin
            r_ino_map[ino_wa] <= ino_wd;
        end
        r_ird <= r_ino_map[IAW'(mem_ra)];
    end

    // Data map memory
    always_ff @(posedge i_clk) begin
        if (dat_we) begin
            r_dat_map[dat_wa] <= dat_wd;
        end
        r_drd <= r_dat_map[DAW'(mem_ra)];
    end

endmodule

@@ tb/bitmap_inode_block_allocator_unit_test.sv @@
`timescale 1ns / 100ps

module bitmap_inode_block_allocator_unit_test;

    localparam int INO_WORDS      = biba_pkg::INODE_MAP_WORDS_DEF;
    localparam int BLK_WORDS      = biba_pkg::DATA_MAP_WORDS_DEF;
    localparam int BPF            = biba_pkg::BLOCKS_PER_FILE_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_SHOWN      = 10;
    localparam int PHASE_ITEMS    = 45;
    localparam int NUM_PHASES     = 5;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // one line of the directed script: a limit write or a request
    typedef struct packed {
        bit                                  is_cfg;
        logic [biba_pkg::CFG_IDX_W-1:0]      reg_idx;
        logic [biba_pkg::CFG_DATA_W-1:0]     reg_val;
        biba_pkg::t_req                      req;
        bit                                  pin;
        biba_pkg::t_res                      first;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    biba_pkg::t_req                  i_req;
    logic                            o_strobe;
    biba_pkg::t_res                  o_res;
    logic                            i_cfg_we;
    logic [biba_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [biba_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // mirror of the allocator state
    logic [31:0]                    ino_map [INO_WORDS];
    logic [31:0]                    blk_map [BLK_WORDS];
    logic [biba_pkg::INO_LIM_W-1:0] ino_limit;
    logic [biba_pkg::DAT_LIM_W-1:0] blk_limit;
    biba_pkg::t_res                 due_results [$];

    // pinned first result for the request being offered
    bit             pin_first;
    biba_pkg::t_res pinned_res;

    t_row script [$];

    int             reqs_taken;
    int             results_checked;
    int             mismatches;
    int             n_allocs;
    int             n_refused;
    int             n_writes;
    int             n_reads;
    int             stall_cycles;
    int             burst_left;
    int             n_before;
    biba_pkg::t_res exp_res;

    bitmap_inode_block_allocator_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic biba_pkg::t_res mk_res(logic st, logic [1:0] kind, logic [31:0] val,
                                              logic lst);
        biba_pkg::t_res r;
        r.status       = st;
        r.result_kind  = kind;
        r.result_value = val;
        r.last         = lst;
        return r;
    endfunction

    // first-fit allocation and map word access on the mirror state
    function automatic void predict_request(biba_pkg::t_req r);
        int          ino_bound;
        int          blk_bound;
        int          ino_idx;
        int          nblk;
        int          i;
        int          blk_idx [BPF];
        logic [31:0] word;
        ino_bound = (int'(ino_limit) < INO_WORDS * 32) ? int'(ino_limit) : INO_WORDS * 32;
        blk_bound = (int'(blk_limit) < BLK_WORDS * 32) ? int'(blk_limit) : BLK_WORDS * 32;
        case (r.req_type)
            biba_pkg::REQ_ALLOC: begin
                n_allocs++;
                ino_idx = -1;
                for (i = 0; i < ino_bound && ino_idx < 0; i++)
                    if (!ino_map[i >> 5][i & 31]) ino_idx = i;
                nblk = 0;
                for (i = 0; i < blk_bound && nblk < BPF; i++) begin
                    if (!blk_map[i >> 5][i & 31]) begin
                        blk_idx[nblk] = i;
                        nblk++;
                    end
                end
                // refused: nothing is marked
                if (ino_idx < 0 || nblk < BPF) begin
                    n_refused++;
                    due_results.push_back(mk_res(biba_pkg::STAT_NOSPACE, biba_pkg::KIND_DONE,
                                                 '0, 1'b1));
                end else begin
                    ino_map[ino_idx >> 5][ino_idx & 31] = 1'b1;
                    due_results.push_back(mk_res(biba_pkg::STAT_OK, biba_pkg::KIND_INODE,
                                                 32'(ino_idx), 1'b0));
                    for (i = 0; i < BPF; i++) begin
                        blk_map[blk_idx[i] >> 5][blk_idx[i] & 31] = 1'b1;
                        due_results.push_back(mk_res(biba_pkg::STAT_OK, biba_pkg::KIND_BLOCK,
                                                     32'(blk_idx[i]), i == BPF - 1));
                    end
                end
            end
            biba_pkg::REQ_WRITE: begin
                n_writes++;
                if (r.map_select == biba_pkg::SEL_INODE) begin
                    if (r.word_index < INO_WORDS) ino_map[r.word_index] = r.word_value;
                end else if (r.word_index < BLK_WORDS) begin
                    blk_map[r.word_index] = r.word_value;
                end
                due_results.push_back(mk_res(biba_pkg::STAT_OK, biba_pkg::KIND_DONE,
                                             '0, 1'b1));
            end
            biba_pkg::REQ_READ: begin
                n_reads++;
                word = '0;
                if (r.map_select == biba_pkg::SEL_INODE) begin
                    if (r.word_index < INO_WORDS) word = ino_map[r.word_index];
                end else if (r.word_index < BLK_WORDS) begin
                    word = blk_map[r.word_index];
                end
                due_results.push_back(mk_res(biba_pkg::STAT_OK, biba_pkg::KIND_WORD,
                                             word, 1'b1));
            end
            default: ;
        endcase
    endfunction

    // result check, limit mirror and request prediction at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (ino_map[w]) ino_map[w] = '0;
            foreach (blk_map[w]) blk_map[w] = '0;
            ino_limit = biba_pkg::INO_LIM_RST;
            blk_limit = biba_pkg::DAT_LIM_RST;
        end else begin
            if (o_strobe) begin
                results_checked++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result: status %0d kind %0d value 0x%08h last %0d",
                                 o_res.status, o_res.result_kind, o_res.result_value,
                                 o_res.last);
                end else begin
                    exp_res = due_results.pop_front();
                    if (o_res.status !== exp_res.status ||
                        o_res.result_kind !== exp_res.result_kind ||
                        o_res.result_value !== exp_res.result_value ||
                        o_res.last !== exp_res.last) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN) begin
                            $display("result %0d: exp st %0d kind %0d val 0x%08h last %0d",
                                     results_checked, exp_res.status, exp_res.result_kind,
                                     exp_res.result_value, exp_res.last);
                            $display("    got st %0d kind %0d val 0x%08h last %0d",
                                     o_res.status, o_res.result_kind, o_res.result_value,
                                     o_res.last);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == biba_pkg::CFG_INODE_LIMIT)
                    ino_limit = i_cfg_data[biba_pkg::INO_LIM_W-1:0];
                else
                    blk_limit = i_cfg_data[biba_pkg::DAT_LIM_W-1:0];
            end
            if (start && !busy) begin
                n_before = due_results.size();
                predict_request(i_req);
                if (pin_first && due_results.size() > n_before)
                    due_results[n_before] = pinned_res;
                reqs_taken++;
            end
        end
    end

    // watchdog on cycles with no request taken and no result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("bitmap_inode_block_allocator_unit: mismatch");
            $finish;
        end
    end

    function automatic t_row rq(logic [1:0] kind, logic sel, logic [6:0] idx,
                                logic [31:0] val, bit pin = 1'b0,
                                biba_pkg::t_res first = '0);
        t_row row;
        row = '0;
        row.req.req_type   = kind;
        row.req.map_select = sel;
        row.req.word_index = idx;
        row.req.word_value = val;
        row.pin            = pin;
        row.first          = first;
        return row;
    endfunction

    function automatic t_row cf(logic [biba_pkg::CFG_IDX_W-1:0] idx,
                                logic [biba_pkg::CFG_DATA_W-1:0] val);
        t_row row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic biba_pkg::t_req random_request();
        biba_pkg::t_req r;
        int             roll;
        roll         = $urandom_range(0, 99);
        r.map_select = 1'($urandom_range(0, 1));
        // mostly low words so that writes shape what the allocator finds
        if ($urandom_range(0, 2) == 0) r.word_index = 7'($urandom_range(0, 127));
        else if (r.map_select == biba_pkg::SEL_DATA) r.word_index = 7'($urandom_range(0, 15));
        else r.word_index = 7'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0:       r.word_value = '0;
            1:       r.word_value = '1;
            default: r.word_value = $urandom;
        endcase
        if (roll < 45) r.req_type = biba_pkg::REQ_ALLOC;
        else if (roll < 70) r.req_type = biba_pkg::REQ_WRITE;
        else if (roll < 96) r.req_type = biba_pkg::REQ_READ;
        else r.req_type = REQ_UNUSED;
        return r;
    endfunction

    // offer a request at the falling edge and hold it until taken
    task automatic send_request(biba_pkg::t_req r, bit pin, biba_pkg::t_res first);
        int n0;
        n0         = reqs_taken;
        pin_first  = pin;
        pinned_res = first;
        start <= 1'b1;
        i_req <= r;
        @(negedge i_clk);
        while (reqs_taken == n0) @(negedge i_clk);
    endtask

    // sender bursts with random gaps in between
    task automatic pace();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
        end
    endtask

    // wait until every result is in and the block has gone idle
    task automatic drain();
        start <= 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [biba_pkg::CFG_IDX_W-1:0] idx,
                               logic [biba_pkg::CFG_DATA_W-1:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        biba_pkg::t_req r;
        int             phase;
        int             n;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = biba_pkg::CFG_INODE_LIMIT;
        i_cfg_data  = '0;
        pin_first   = 1'b0;
        pinned_res  = '0;

        // directed script: fresh maps, bounds, refusals, ignored requests
        script.push_back(rq(biba_pkg::REQ_READ, biba_pkg::SEL_INODE, 7'd0, 32'd0, 1'b1,
                            mk_res(biba_pkg::STAT_OK, biba_pkg::KIND_WORD, 32'd0, 1'b1)));
        script.push_back(rq(biba_pkg::REQ_READ, biba_pkg::SEL_DATA, 7'd127, 32'd0, 1'b1,
                            mk_res(biba_pkg::STAT_OK, biba_pkg::KIND_WORD, 32'd0, 1'b1)));
        script.push_back(rq(biba_pkg::REQ_READ, biba_pkg::SEL_INODE, 7'd127, 32'd0, 1'b1,
                            mk_res(biba_pkg::STAT_OK, biba_pkg::KIND_WORD, 32'd0, 1'b1)));
        script.push_back(rq(biba_pkg::REQ_ALLOC, biba_pkg::SEL_INODE, 7'd0, 32'd0, 1'b1,
                            mk_res(biba_pkg::STAT_OK, biba_pkg::KIND_INODE, 32'd0, 1'b0)));
        script.push_back(rq(biba_pkg::REQ_READ, biba_pkg::SEL_INODE, 7'd0, 32'd0));
        script.push_back(rq(biba_pkg::REQ_READ, biba_pkg::SEL_DATA, 7'd0, 32'd0));
        script.push_back(rq(biba_pkg::REQ_WRITE, biba_pkg::SEL_INODE, 7'd31, 32'hFFFF_FFFF,
                            1'b1,
                            mk_res(biba_pkg::STAT_OK, biba_pkg::KIND_DONE, 32'd0, 1'b1)));
        // write past the inode map is dropped but still answered
        script.push_back(rq(biba_pkg::REQ_WRITE, biba_pkg::SEL_INODE, 7'd100, 32'hDEAD_BEEF,
                            1'b1,
                            mk_res(biba_pkg::STAT_OK, biba_pkg::KIND_DONE, 32'd0, 1'b1)));
        script.push_back(rq(biba_pkg::REQ_READ, biba_pkg::SEL_INODE, 7'd100, 32'd0, 1'b1,
                            mk_res(biba_pkg::STAT_OK, biba_pkg::KIND_WORD, 32'd0, 1'b1)));
        script.push_back(rq(biba_pkg::REQ_WRITE, biba_pkg::SEL_DATA, 7'd127, 32'hFFFF_FFFF,
                            1'b1,
                            mk_res(biba_pkg::STAT_OK, biba_pkg::KIND_DONE, 32'd0, 1'b1)));
        script.push_back(rq(biba_pkg::REQ_READ, biba_pkg::SEL_DATA, 7'd127, 32'd0));
        script.push_back(rq(REQ_UNUSED, biba_pkg::SEL_DATA, 7'd127, 32'hFFFF_FFFF));
        // inode 0 taken, only one inode usable
        script.push_back(cf(biba_pkg::CFG_INODE_LIMIT, 13'd1));
        script.push_back(rq(biba_pkg::REQ_ALLOC, biba_pkg::SEL_INODE, 7'd0, 32'd0, 1'b1,
                            mk_res(biba_pkg::STAT_NOSPACE, biba_pkg::KIND_DONE, 32'd0, 1'b1)));
        script.push_back(cf(biba_pkg::CFG_INODE_LIMIT, 13'd1024));
        // blocks 0..3 taken, only four blocks usable
        script.push_back(cf(biba_pkg::CFG_DATA_LIMIT, 13'd4));
        script.push_back(rq(biba_pkg::REQ_ALLOC, biba_pkg::SEL_DATA, 7'd0, 32'd0, 1'b1,
                            mk_res(biba_pkg::STAT_NOSPACE, biba_pkg::KIND_DONE, 32'd0, 1'b1)));
        script.push_back(cf(biba_pkg::CFG_DATA_LIMIT, 13'd0));
        script.push_back(rq(biba_pkg::REQ_ALLOC, biba_pkg::SEL_INODE, 7'd0, 32'd0, 1'b1,
                            mk_res(biba_pkg::STAT_NOSPACE, biba_pkg::KIND_DONE, 32'd0, 1'b1)));
        script.push_back(cf(biba_pkg::CFG_DATA_LIMIT, 13'd4096));
        script.push_back(cf(biba_pkg::CFG_INODE_LIMIT, 13'd0));
        script.push_back(rq(biba_pkg::REQ_ALLOC, biba_pkg::SEL_INODE, 7'd0, 32'd0, 1'b1,
                            mk_res(biba_pkg::STAT_NOSPACE, biba_pkg::KIND_DONE, 32'd0, 1'b1)));
        // limits past the map size clamp to the map
        script.push_back(cf(biba_pkg::CFG_INODE_LIMIT, 13'd2047));
        script.push_back(cf(biba_pkg::CFG_DATA_LIMIT, 13'd8191));
        script.push_back(rq(biba_pkg::REQ_ALLOC, biba_pkg::SEL_DATA, 7'd127, 32'hFFFF_FFFF));

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].is_cfg) begin
                write_limit(script[k].reg_idx, script[k].reg_val);
            end else begin
                send_request(script[k].req, script[k].pin, script[k].first);
                pace();
            end
        end

        // random phases, each under its own pair of limits
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_limit(biba_pkg::CFG_INODE_LIMIT, 13'd1024);
                    write_limit(biba_pkg::CFG_DATA_LIMIT, 13'd4096);
                end
                1: begin
                    write_limit(biba_pkg::CFG_INODE_LIMIT,
                                biba_pkg::CFG_DATA_W'($urandom_range(0, 64)));
                    write_limit(biba_pkg::CFG_DATA_LIMIT,
                                biba_pkg::CFG_DATA_W'($urandom_range(0, 256)));
                end
                2: begin
                    write_limit(biba_pkg::CFG_INODE_LIMIT, 13'd2047);
                    write_limit(biba_pkg::CFG_DATA_LIMIT, 13'd8191);
                end
                3: begin
                    write_limit(biba_pkg::CFG_INODE_LIMIT,
                                biba_pkg::CFG_DATA_W'($urandom_range(0, 1024)));
                    write_limit(biba_pkg::CFG_DATA_LIMIT,
                                biba_pkg::CFG_DATA_W'($urandom_range(0, 4096)));
                end
                default: begin
                    write_limit(biba_pkg::CFG_INODE_LIMIT,
                                biba_pkg::CFG_DATA_W'($urandom_range(1, 40)));
                    write_limit(biba_pkg::CFG_DATA_LIMIT,
                                biba_pkg::CFG_DATA_W'($urandom_range(4, 160)));
                end
            endcase
            n = 0;
            while (n < PHASE_ITEMS) begin
                r = random_request();
                send_request(r, 1'b0, '0);
                pace();
                if (r.req_type != REQ_UNUSED) n++;
            end
        end

        // let the last results arrive, then a short tail for strays
        start <= 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("covered %0d requests: %0d allocations (%0d refused), %0d writes, %0d reads",
                 reqs_taken, n_allocs, n_refused, n_writes, n_reads);
        $display("%0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("bitmap_inode_block_allocator_unit: match");
        end else begin
            $display("bitmap_inode_block_allocator_unit: mismatch");
        end
        $finish;
    end

endmodule
